/* rtl/ugn_pkg.sv */
// ----------------------------------------------------------------------------
// Uniform grid neighbor cells - shared definitions
// Sizes, register map, opcodes and the result groups passed between units.
// ----------------------------------------------------------------------------
package ugn_pkg;

    localparam int MAX_PARTICLES      = 1024;
    localparam int MAX_CELLS_PER_AXIS = 64;

    localparam int PART_AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int AXIS_W   = 7;
    localparam int NXY_W    = 2 * AXIS_W;
    localparam int IDX_W    = 18;
    localparam int NUM_REGS = 7;
    localparam int CFG_AW   = $clog2(NUM_REGS * 4);

    localparam logic ST_OK          = 1'b0;
    localparam logic ST_OUT_OF_GRID = 1'b1;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_INV_VOX  = 3'd3,
        REG_CELLS_X  = 3'd4,
        REG_CELLS_Y  = 3'd5,
        REG_CELLS_Z  = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_PLACE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic [AXIS_W-1:0] cx;
        logic [AXIS_W-1:0] cy;
        logic [AXIS_W-1:0] cz;
    } t_quant_res;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quot;
        logic [NXY_W-1:0] rem;
    } t_div_res;

    // zero acts as one, oversize clamps to the axis limit
    function automatic logic [AXIS_W-1:0] axis_size(input logic [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] r;
        if (v == '0) begin
            r = AXIS_W'(1);
        end else if (32'(v) > 32'(MAX_CELLS_PER_AXIS)) begin
            r = AXIS_W'(MAX_CELLS_PER_AXIS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/uniform_grid_neighbor_cells.sv */
// ----------------------------------------------------------------------------
// Uniform grid neighbor cells
// Place: start, three axes in turn in the quantizer (difference, magnitude,
// low and high product, rounding), handoff, index math, output register.
// Query: a memory read and two 18-bit divides before the first neighbor,
// then the 27 offsets in turn up to the last in-grid one, one per cycle,
// in-grid or not; an in-grid offset waits while the output slot is busy.
// One item at a time, taken once the last result is registered.
// Reset loads register defaults; particle memory is not cleared.
// ----------------------------------------------------------------------------
module uniform_grid_neighbor_cells (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_opcode,
    input  logic [9:0]                 i_particle_id,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_y,
    input  logic signed [31:0]         i_pos_z,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [17:0]                o_cell_index,
    output logic                       o_status,
    output logic                       o_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ugn_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ugn_pkg::*;

    localparam int PW = NXY_W + AXIS_W;
    localparam int ZW = IDX_W + 1;
    localparam int SW = IDX_W + 2;

    localparam logic [1:0] OFF_NEG = 2'd0;
    localparam logic [1:0] OFF_MID = 2'd1;
    localparam logic [1:0] OFF_POS = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QUANT,
        S_IDX1,
        S_IDX2,
        S_POUT,
        S_RD,
        S_DSTART,
        S_DIV1,
        S_DIV2,
        S_MASK,
        S_ENUM
    } t_state;

    // configuration
    logic signed [31:0] r_org_x;
    logic signed [31:0] r_org_y;
    logic signed [31:0] r_org_z;
    logic [31:0]        r_inv;
    logic [AXIS_W-1:0]  r_cells_x;
    logic [AXIS_W-1:0]  r_cells_y;
    logic [AXIS_W-1:0]  r_cells_z;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_org_z   <= '0;
            r_inv     <= 32'd65536;
            r_cells_x <= AXIS_W'(64);
            r_cells_y <= AXIS_W'(64);
            r_cells_z <= AXIS_W'(64);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORIGIN_X: r_org_x   <= pwdata;
                REG_ORIGIN_Y: r_org_y   <= pwdata;
                REG_ORIGIN_Z: r_org_z   <= pwdata;
                REG_INV_VOX:  r_inv     <= pwdata;
                REG_CELLS_X:  r_cells_x <= pwdata[AXIS_W-1:0];
                REG_CELLS_Y:  r_cells_y <= pwdata[AXIS_W-1:0];
                REG_CELLS_Z:  r_cells_z <= pwdata[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ORIGIN_X: prdata = r_org_x;
            REG_ORIGIN_Y: prdata = r_org_y;
            REG_ORIGIN_Z: prdata = r_org_z;
            REG_INV_VOX:  prdata = r_inv;
            REG_CELLS_X:  prdata = {{(32-AXIS_W){1'b0}}, r_cells_x};
            REG_CELLS_Y:  prdata = {{(32-AXIS_W){1'b0}}, r_cells_y};
            REG_CELLS_Z:  prdata = {{(32-AXIS_W){1'b0}}, r_cells_z};
            default:      prdata = '0;
        endcase
    end

    // datapath registers
    t_state             r_state;
    logic               r_qstart;
    logic [9:0]         r_id;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic signed [31:0] r_pos_z;
    logic [NXY_W-1:0]   r_nxy;
    logic [NXY_W-1:0]   r_t;
    logic [IDX_W-1:0]   r_cidx;
    logic               r_status;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_z;
    logic [AXIS_W-1:0]  r_y;
    logic [AXIS_W-1:0]  r_x;
    logic [2:0]         r_vx;
    logic [2:0]         r_vy;
    logic [2:0]         r_vz;
    logic [1:0]         r_lx;
    logic [1:0]         r_ly;
    logic [1:0]         r_lz;
    logic [1:0]         r_dx;
    logic [1:0]         r_dy;
    logic [1:0]         r_dz;
    logic               r_o_valid;
    logic [IDX_W-1:0]   r_o_cell;
    logic               r_o_status;
    logic               r_o_last;

    logic [AXIS_W-1:0] nx;
    logic [AXIS_W-1:0] ny;
    logic [AXIS_W-1:0] nz;

    assign nx = axis_size(r_cells_x);
    assign ny = axis_size(r_cells_y);
    assign nz = axis_size(r_cells_z);

    // quantizer
    t_quant_res q_res;

    ugn_quant u_quant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_qstart),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_pos_z (r_pos_z),
        .i_org_x (r_org_x),
        .i_org_y (r_org_y),
        .i_org_z (r_org_z),
        .i_inv   (r_inv),
        .i_nx    (nx),
        .i_ny    (ny),
        .i_nz    (nz),
        .o_res   (q_res)
    );

    // particle cell memory
    logic             id_ok;
    logic             ram_we;
    logic [IDX_W-1:0] ram_rdata;
    logic [IDX_W-1:0] qidx;
    logic [PW-1:0]    idx_full;

    assign id_ok    = ({22'b0, r_id} < 32'(MAX_PARTICLES));
    assign idx_full = {{AXIS_W{1'b0}}, r_t} * {{NXY_W{1'b0}}, nx}
                    + {{NXY_W{1'b0}}, q_res.cx};
    assign ram_we   = (r_state == S_IDX2) && id_ok;
    assign qidx     = id_ok ? ram_rdata : '0;

    ugn_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PARTICLES)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (PART_AW'(r_id)),
        .i_wdata (idx_full[IDX_W-1:0]),
        .i_raddr (PART_AW'(r_id)),
        .o_rdata (ram_rdata)
    );

    // cell decode
    t_div_res         d_res;
    logic             d_start;
    logic [IDX_W-1:0] d_dividend;
    logic [NXY_W-1:0] d_divisor;

    always_comb begin
        d_start    = (r_state == S_DSTART) || ((r_state == S_DIV1) && d_res.done);
        d_dividend = (r_state == S_DSTART) ? qidx : IDX_W'(d_res.rem);
        d_divisor  = (r_state == S_DSTART) ? r_nxy : NXY_W'(nx);
    end

    ugn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (d_start),
        .i_dividend (d_dividend),
        .i_divisor  (d_divisor),
        .o_res      (d_res)
    );

    // neighborhood masks
    logic [2:0]     vx;
    logic [2:0]     vy;
    logic [2:0]     vz;
    logic [ZW-1:0]  z_ext;
    logic [ZW-1:0]  nz_ext;

    always_comb begin
        z_ext  = {1'b0, r_z};
        nz_ext = ZW'(nz);
        vx     = {(({1'b0, r_x} + (AXIS_W+1)'(1)) < {1'b0, nx}), 1'b1, (r_x != '0)};
        vy     = {(({1'b0, r_y} + (AXIS_W+1)'(1)) < {1'b0, ny}), 1'b1, (r_y != '0)};
        vz[0]  = (r_z != '0) && ((z_ext - ZW'(1)) < nz_ext);
        vz[1]  = (z_ext < nz_ext);
        vz[2]  = ((z_ext + ZW'(1)) < nz_ext);
    end

    // neighbor walk
    logic          slot_free;
    logic          cur_hit;
    logic          cur_last;
    logic [SW-1:0] nxy_ext;
    logic [SW-1:0] nx_ext;
    logic [SW-1:0] off_x;
    logic [SW-1:0] off_y;
    logic [SW-1:0] off_z;
    logic [SW-1:0] nb_cell;

    always_comb begin
        slot_free = !r_o_valid || i_ready;
        cur_hit   = r_vx[r_dx] && r_vy[r_dy] && r_vz[r_dz];
        cur_last  = (r_dx == r_lx) && (r_dy == r_ly) && (r_dz == r_lz);
        nxy_ext   = SW'(r_nxy);
        nx_ext    = SW'(nx);
        case (r_dx)
            OFF_NEG: off_x = '1;
            OFF_POS: off_x = SW'(1);
            default: off_x = '0;
        endcase
        case (r_dy)
            OFF_NEG: off_y = '0 - nx_ext;
            OFF_POS: off_y = nx_ext;
            default: off_y = '0;
        endcase
        case (r_dz)
            OFF_NEG: off_z = '0 - nxy_ext;
            OFF_POS: off_z = nxy_ext;
            default: off_z = '0;
        endcase
        nb_cell = SW'(r_idx) + off_x + off_y + off_z;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qstart  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_qstart <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_id    <= i_particle_id;
                        r_pos_x <= i_pos_x;
                        r_pos_y <= i_pos_y;
                        r_pos_z <= i_pos_z;
                        r_nxy   <= {{AXIS_W{1'b0}}, nx} * {{AXIS_W{1'b0}}, ny};
                        if (i_opcode == OP_QUERY) begin
                            r_state <= S_RD;
                        end else begin
                            r_qstart <= 1'b1;
                            r_state  <= S_QUANT;
                        end
                    end
                end
                S_QUANT: begin
                    if (q_res.done) begin
                        if (q_res.ok) begin
                            r_state <= S_IDX1;
                        end else begin
                            r_cidx   <= '0;
                            r_status <= ST_OUT_OF_GRID;
                            r_state  <= S_POUT;
                        end
                    end
                end
                S_IDX1: begin
                    r_t <= {{AXIS_W{1'b0}}, q_res.cz} * {{AXIS_W{1'b0}}, ny}
                         + {{AXIS_W{1'b0}}, q_res.cy};
                    r_state <= S_IDX2;
                end
                S_IDX2: begin
                    r_cidx   <= idx_full[IDX_W-1:0];
                    r_status <= ST_OK;
                    r_state  <= S_POUT;
                end
                S_POUT: begin
                    if (slot_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_cell   <= r_cidx;
                        r_o_status <= r_status;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_idx   <= qidx;
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (d_res.done) begin
                        r_z     <= d_res.quot;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (d_res.done) begin
                        r_y     <= AXIS_W'(d_res.quot);
                        r_x     <= AXIS_W'(d_res.rem);
                        r_state <= S_MASK;
                    end
                end
                S_MASK: begin
                    r_vx <= vx;
                    r_vy <= vy;
                    r_vz <= vz;
                    r_lx <= vx[2] ? OFF_POS : OFF_MID;
                    r_ly <= vy[2] ? OFF_POS : OFF_MID;
                    r_lz <= vz[2] ? OFF_POS : (vz[1] ? OFF_MID : OFF_NEG);
                    r_dx <= OFF_NEG;
                    r_dy <= OFF_NEG;
                    r_dz <= OFF_NEG;
                    // stored cell more than one layer beyond current z range: nothing to report
                    r_state <= (vz == '0) ? S_IDLE : S_ENUM;
                end
                S_ENUM: begin
                    if (!cur_hit || slot_free) begin
                        if (cur_hit) begin
                            r_o_valid  <= 1'b1;
                            r_o_cell   <= nb_cell[IDX_W-1:0];
                            r_o_status <= ST_OK;
                            r_o_last   <= cur_last;
                        end
                        if (cur_hit && cur_last) begin
                            r_state <= S_IDLE;
                        end else if (r_dz == OFF_POS) begin
                            r_dz <= OFF_NEG;
                            if (r_dy == OFF_POS) begin
                                r_dy <= OFF_NEG;
                                r_dx <= r_dx + 2'd1;
                            end else begin
                                r_dy <= r_dy + 2'd1;
                            end
                        end else begin
                            r_dz <= r_dz + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_cell_index = r_o_cell;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

endmodule

/* rtl/ugn_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ugn_ram #(
    parameter int   WIDTH = 18,
    parameter int   DEPTH = 1024,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ugn_div.sv */
// ----------------------------------------------------------------------------
// Cell index divider
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module ugn_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ugn_pkg::IDX_W-1:0] i_dividend,
    input  logic [ugn_pkg::NXY_W-1:0] i_divisor,
    output ugn_pkg::t_div_res        o_res
);
    import ugn_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_dstate;

    t_dstate          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [IDX_W-1:0] r_quot;
    logic [NXY_W-1:0] r_rem;
    logic [NXY_W-1:0] r_div;

    logic [NXY_W:0]   trial;
    logic [NXY_W:0]   diff;
    logic             ge;
    logic [NXY_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quot[IDX_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[NXY_W-1:0] : trial[NXY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_quot  <= i_dividend;
                        r_rem   <= '0;
                        r_div   <= i_divisor;
                        r_cnt   <= CNT_W'(IDX_W);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= n_rem;
                    r_quot <= {r_quot[IDX_W-2:0], ge};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

/* rtl/ugn_quant.sv */
// ----------------------------------------------------------------------------
// Position quantizer
// Per axis: subtract origin, scale by reciprocal voxel size, round half away
// from zero, range check. One shared split multiplier, axes in turn.
// ----------------------------------------------------------------------------
module ugn_quant (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [31:0]        i_pos_x,
    input  logic signed [31:0]        i_pos_y,
    input  logic signed [31:0]        i_pos_z,
    input  logic signed [31:0]        i_org_x,
    input  logic signed [31:0]        i_org_y,
    input  logic signed [31:0]        i_org_z,
    input  logic [31:0]               i_inv,
    input  logic [ugn_pkg::AXIS_W-1:0] i_nx,
    input  logic [ugn_pkg::AXIS_W-1:0] i_ny,
    input  logic [ugn_pkg::AXIS_W-1:0] i_nz,
    output ugn_pkg::t_quant_res       o_res
);
    import ugn_pkg::*;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_DIFF,
        Q_MAG,
        Q_MLO,
        Q_MHI,
        Q_RND
    } t_qstate;

    t_qstate           r_state;
    logic [1:0]        r_axis;
    logic              r_done;
    logic              r_ok;
    logic [AXIS_W-1:0] r_cx;
    logic [AXIS_W-1:0] r_cy;
    logic [AXIS_W-1:0] r_cz;
    logic [32:0]       r_diff;
    logic              r_neg;
    logic [32:0]       r_mag;
    logic [48:0]       r_plo;
    logic [48:0]       r_phi;

    logic signed [31:0] sel_pos;
    logic signed [31:0] sel_org;
    logic [AXIS_W-1:0]  sel_n;
    logic [65:0]        sum;
    logic [33:0]        q;
    logic               ax_ok;
    logic [AXIS_W-1:0]  ax_cell;

    always_comb begin
        case (r_axis)
            AX_Y: begin
                sel_pos = i_pos_y;
                sel_org = i_org_y;
                sel_n   = i_ny;
            end
            AX_Z: begin
                sel_pos = i_pos_z;
                sel_org = i_org_z;
                sel_n   = i_nz;
            end
            default: begin
                sel_pos = i_pos_x;
                sel_org = i_org_x;
                sel_n   = i_nx;
            end
        endcase
        sum     = {1'b0, r_phi, 16'b0} + {17'b0, r_plo} + 66'h0_8000_0000;
        q       = sum[65:32];
        ax_ok   = r_neg ? (q == '0) : (q < {27'b0, sel_n});
        ax_cell = r_neg ? '0 : q[AXIS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_axis  <= AX_X;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                Q_IDLE: begin
                    if (i_start) begin
                        r_axis  <= AX_X;
                        r_ok    <= 1'b1;
                        r_state <= Q_DIFF;
                    end
                end
                Q_DIFF: begin
                    r_diff  <= {sel_pos[31], sel_pos} - {sel_org[31], sel_org};
                    r_state <= Q_MAG;
                end
                Q_MAG: begin
                    r_neg   <= r_diff[32];
                    r_mag   <= r_diff[32] ? (~r_diff + 33'd1) : r_diff;
                    r_state <= Q_MLO;
                end
                Q_MLO: begin
                    r_plo   <= {16'b0, r_mag} * {33'b0, i_inv[15:0]};
                    r_state <= Q_MHI;
                end
                Q_MHI: begin
                    r_phi   <= {16'b0, r_mag} * {33'b0, i_inv[31:16]};
                    r_state <= Q_RND;
                end
                Q_RND: begin
                    r_ok <= r_ok & ax_ok;
                    case (r_axis)
                        AX_Y:    r_cy <= ax_cell;
                        AX_Z:    r_cz <= ax_cell;
                        default: r_cx <= ax_cell;
                    endcase
                    if (r_axis == AX_Z) begin
                        r_done  <= 1'b1;
                        r_state <= Q_IDLE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= Q_DIFF;
                    end
                end
                default: r_state <= Q_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.ok   = r_ok;
    assign o_res.cx   = r_cx;
    assign o_res.cy   = r_cy;
    assign o_res.cz   = r_cz;

endmodule

/* tb/uniform_grid_neighbor_cells_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform grid neighbor cells - testbench
// Sends place and query items over the input channel and checks every result
// transfer against an in-bench model of the grid: quantization, cell storage
// and 3x3x3 neighbor walk. A directed table comes first, then random phases
// under several grid settings written over the register port. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module uniform_grid_neighbor_cells_tb;
    import ugn_pkg::*;

    localparam int   ITEMS_PER_PHASE = 40;
    localparam int   NUM_PHASES      = 8;
    localparam int   SETTLE_CYCLES   = 100;
    localparam int   HOLD_CYCLES     = 400;

    typedef struct packed {
        t_opcode     op;
        logic [9:0]  pid;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        typed;
        logic [17:0] exp_idx;
        logic        status;
    } t_work_item;

    typedef struct packed {
        logic [17:0] cell_idx;
        logic        status;
        logic        last;
    } t_cell_res;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                i_opcode      = OP_PLACE;
    logic [9:0]          i_particle_id = '0;
    logic signed [31:0]  i_pos_x       = '0;
    logic signed [31:0]  i_pos_y       = '0;
    logic signed [31:0]  i_pos_z       = '0;
    logic                i_ready       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [CFG_AW-1:0]   paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic                o_ready;
    logic                o_valid;
    logic [17:0]         o_cell_index;
    logic                o_status;
    logic                o_last;
    logic [31:0]         prdata;
    logic                pready;

    // grid settings as the block should see them
    logic [31:0] org_x   = '0;
    logic [31:0] org_y   = '0;
    logic [31:0] org_z   = '0;
    logic [31:0] inv_vox = 32'h0001_0000;
    logic [6:0]  cells_x = 7'd64;
    logic [6:0]  cells_y = 7'd64;
    logic [6:0]  cells_z = 7'd64;

    logic [17:0] stored_cell [MAX_PARTICLES];
    bit          is_placed   [MAX_PARTICLES];
    int          placed_ids [$];
    t_cell_res   pending_cells [$];

    int   n_errors = 0;
    int   n_sent   = 0;
    int   tx_quiet = 0;
    int   rx_quiet = 0;
    logic rx_hold  = 1'b0;

    t_work_item plan [0:17] = '{
        '{OP_PLACE, 10'd0,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 18'd0, ST_OK},
        '{OP_PLACE, 10'd1,    32'h003F_0000, 32'h003F_0000, 32'h003F_0000,
          1'b1, 18'd262143, ST_OK},
        '{OP_PLACE, 10'd2,    32'h003F_8000, 32'h003F_8000, 32'h003F_8000,
          1'b1, 18'd0, ST_OUT_OF_GRID},
        '{OP_PLACE, 10'd3,    32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 18'd0, ST_OUT_OF_GRID},
        '{OP_PLACE, 10'd4,    32'hFFFF_8001, 32'hFFFF_8001, 32'hFFFF_8001,
          1'b1, 18'd0, ST_OK},
        '{OP_PLACE, 10'd5,    32'h0000_8000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 18'd1, ST_OK},
        '{OP_PLACE, 10'd6,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 18'd0, ST_OUT_OF_GRID},
        '{OP_PLACE, 10'd7,    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          1'b1, 18'd0, ST_OUT_OF_GRID},
        '{OP_PLACE, 10'd1023, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
          1'b1, 18'd12417, ST_OK},
        '{OP_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 18'd0, ST_OK},
        '{OP_QUERY, 10'd1,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 18'd0, ST_OK},
        '{OP_QUERY, 10'd1023, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 18'd0, ST_OK},
        '{OP_QUERY, 10'd4,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 18'd0, ST_OK},
        '{OP_QUERY, 10'd5,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 18'd0, ST_OK},
        '{OP_PLACE, 10'd8,    32'h0015_5555, 32'h002A_AAAA, 32'h0020_7FFF,
          1'b0, 18'd0, ST_OK},
        '{OP_QUERY, 10'd8,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 18'd0, ST_OK},
        '{OP_PLACE, 10'd0,    32'h0000_7FFF, 32'h003E_8000, 32'h001F_FFFF,
          1'b0, 18'd0, ST_OK},
        '{OP_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 18'd0, ST_OK}
    };

    uniform_grid_neighbor_cells u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_particle_id (i_particle_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_index  (o_cell_index),
        .o_status      (o_status),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic note_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic int axis_cells(input logic [6:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_CELLS_PER_AXIS) return MAX_CELLS_PER_AXIS;
        return int'(v);
    endfunction

    // nearest cell, halves away from zero; 0 when outside 0..n-1
    function automatic logic quantize_axis(input logic [31:0] pos, input logic [31:0] org,
                                           input int n, output int pos_cell);
        longint      diff;
        logic [63:0] mag;
        logic [64:0] prod;
        logic [32:0] q;
        diff = longint'($signed(pos)) - longint'($signed(org));
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        prod = 65'(mag) * 65'(inv_vox) + 65'h0_8000_0000;
        q    = prod[64:32];
        pos_cell = 0;
        if (diff < 0) return (q == '0);
        if (q >= 33'(n)) return 1'b0;
        pos_cell = int'(q);
        return 1'b1;
    endfunction

    function automatic t_cell_res place_particle(input logic [9:0] pid, input logic [31:0] px,
                                                 input logic [31:0] py, input logic [31:0] pz);
        int        nx, ny, nz, cx, cy, cz;
        logic      okx, oky, okz;
        t_cell_res r;
        nx  = axis_cells(cells_x);
        ny  = axis_cells(cells_y);
        nz  = axis_cells(cells_z);
        okx = quantize_axis(px, org_x, nx, cx);
        oky = quantize_axis(py, org_y, ny, cy);
        okz = quantize_axis(pz, org_z, nz, cz);
        r.last = 1'b1;
        if (okx && oky && okz) begin
            r.cell_idx = 18'(cz * nx * ny + cy * nx + cx);
            r.status   = ST_OK;
            stored_cell[pid] = r.cell_idx;
            if (!is_placed[pid]) begin
                is_placed[pid] = 1'b1;
                placed_ids = {placed_ids, int'(pid)};
            end
        end else begin
            r.cell_idx = '0;
            r.status   = ST_OUT_OF_GRID;
        end
        return r;
    endfunction

    task automatic expect_neighbors(input logic [9:0] pid);
        int        nx, ny, nz, nxy, stored, x, y, z, rem, ax, ay, az, dx, dy, dz;
        t_cell_res r;
        t_cell_res hits [$];
        nx     = axis_cells(cells_x);
        ny     = axis_cells(cells_y);
        nz     = axis_cells(cells_z);
        nxy    = nx * ny;
        stored = int'(stored_cell[pid]);
        z      = stored / nxy;
        rem    = stored - z * nxy;
        y      = rem / nx;
        x      = rem % nx;
        for (dx = -1; dx <= 1; dx++) begin
            for (dy = -1; dy <= 1; dy++) begin
                for (dz = -1; dz <= 1; dz++) begin
                    ax = x + dx;
                    ay = y + dy;
                    az = z + dz;
                    if (ax >= 0 && ay >= 0 && az >= 0 && ax < nx && ay < ny && az < nz) begin
                        r.cell_idx = 18'(az * nxy + ay * nx + ax);
                        r.status   = ST_OK;
                        r.last     = 1'b0;
                        hits = {hits, r};
                    end
                end
            end
        end
        if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
        foreach (hits[k]) pending_cells = {pending_cells, hits[k]};
    endtask

    // quiet stretches give back-to-back transfers
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // position aimed at a cell from -1 to n along one axis
    function automatic logic [31:0] aim_axis(input logic [31:0] org, input logic [6:0] creg);
        longint vox, half, jit, c, spot;
        int     pick;
        vox  = longint'(64'h1_0000_0000 / {32'd0, inv_vox});
        half = vox / 2;
        c    = longint'($urandom_range(0, axis_cells(creg) + 1)) - 1;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            jit = half;
        end else if (pick == 1) begin
            jit = -half;
        end else begin
            jit = longint'($urandom) % (2 * half + 1) - half;
        end
        spot = longint'($signed(org)) + c * vox + jit;
        return spot[31:0];
    endfunction

    task automatic offer(input t_work_item it);
        int        gap;
        t_cell_res r;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= it.op;
        i_particle_id <= it.pid;
        i_pos_x       <= it.px;
        i_pos_y       <= it.py;
        i_pos_z       <= it.pz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
        if (it.op == OP_PLACE) begin
            r = place_particle(it.pid, it.px, it.py, it.pz);
            if (it.typed) begin
                r.cell_idx = it.exp_idx;
                r.status   = it.status;
            end
            pending_cells = {pending_cells, r};
        end else begin
            expect_neighbors(it.pid);
        end
    endtask

    task automatic settle();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (pending_cells.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_cells.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_cells.size()));
            pending_cells.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx r, input logic [31:0] v);
        logic [31:0] want;
        want = v;
        case (r)
            REG_ORIGIN_X: org_x   = v;
            REG_ORIGIN_Y: org_y   = v;
            REG_ORIGIN_Z: org_z   = v;
            REG_INV_VOX:  inv_vox = v;
            REG_CELLS_X: begin
                cells_x = v[6:0];
                want    = {25'd0, v[6:0]};
            end
            REG_CELLS_Y: begin
                cells_y = v[6:0];
                want    = {25'd0, v[6:0]};
            end
            REG_CELLS_Z: begin
                cells_z = v[6:0];
                want    = {25'd0, v[6:0]};
            end
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(int'(r) * 4);
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            note_mismatch($sformatf("register %s reads 0x%08h, wrote 0x%08h",
                                    r.name(), prdata, want));
        end
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                            input logic [31:0] inv, input logic [6:0] nx, input logic [6:0] ny,
                            input logic [6:0] nz);
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_ORIGIN_Z, oz);
        reg_write(REG_INV_VOX, inv);
        reg_write(REG_CELLS_X, {25'd0, nx});
        reg_write(REG_CELLS_Y, {25'd0, ny});
        reg_write(REG_CELLS_Z, {25'd0, nz});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] near_origin();
        return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endfunction

    // result side
    initial begin
        int        stall;
        t_cell_res w;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap(rx_quiet);
            if (stall > 0 || rx_hold) begin
                i_ready <= 1'b0;
                while (stall > 0 || rx_hold) begin
                    @(posedge i_clk);
                    if (stall > 0) stall--;
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_cells.size() == 0) begin
                note_mismatch($sformatf("unexpected result cell %0d status %0b last %0b",
                                        o_cell_index, o_status, o_last));
            end else begin
                w = pending_cells.pop_front();
                if (o_cell_index !== w.cell_idx)
                    note_mismatch($sformatf("cell_index %0d, want %0d", o_cell_index,
                                            w.cell_idx));
                if (o_status !== w.status)
                    note_mismatch($sformatf("status %0b, want %0b", o_status, w.status));
                if (o_last !== w.last)
                    note_mismatch($sformatf("last %0b, want %0b", o_last, w.last));
            end
        end
    end

    // long hold-off on the result side while items keep coming
    initial begin
        wait (n_sent == 60);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TIMEOUT @%0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int         p;
        int         k;
        int         sel;
        t_work_item it;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (k = 0; k < 18; k++) offer(plan[k]);
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 7'd64, 7'd64, 7'd64);
                1: set_grid(32'h8000_0000, 32'h7FFF_FFFF, near_origin(), 32'h0002_0000,
                            7'd64, 7'd64, 7'd64);
                2: set_grid(near_origin(), near_origin(), near_origin(), 32'h0001_0000,
                            7'd1, 7'd1, 7'd1);
                3: set_grid(near_origin(), near_origin(), near_origin(), 32'h0000_4000,
                            7'd0, 7'd127, 7'd5);
                4: set_grid(near_origin(), near_origin(), near_origin(), 32'h0000_0001,
                            7'd2, 7'd2, 7'd2);
                5: set_grid(near_origin(), near_origin(), near_origin(), 32'hFFFF_FFFF,
                            7'd3, 7'd64, 7'd7);
                6: set_grid($urandom, $urandom, $urandom, $urandom_range(1, 32'h0004_0000),
                            7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                            7'($urandom_range(1, 64)));
                default: set_grid(near_origin(), near_origin(), near_origin(),
                                  $urandom_range(32'h100, 32'h0010_0000), 7'd64, 7'd1, 7'd64);
            endcase
            repeat (ITEMS_PER_PHASE) begin
                sel        = $urandom_range(0, 9);
                it.typed   = 1'b0;
                it.exp_idx = '0;
                it.status  = ST_OK;
                it.px      = $urandom;
                it.py      = $urandom;
                it.pz      = $urandom;
                it.pid     = 10'($urandom_range(0, MAX_PARTICLES - 1));
                if (sel < 5 || placed_ids.size() == 0) begin
                    it.op = OP_PLACE;
                    it.px = aim_axis(org_x, cells_x);
                    it.py = aim_axis(org_y, cells_y);
                    it.pz = aim_axis(org_z, cells_z);
                end else if (sel < 9) begin
                    it.op  = OP_QUERY;
                    it.pid = 10'(placed_ids[$urandom_range(0, placed_ids.size() - 1)]);
                end else begin
                    it.op = OP_PLACE;
                end
                offer(it);
            end
        end
        settle();
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
